/* rtl/ssm_pkg.sv */
package ssm_pkg;

   // Item modes
   localparam logic [1:0] MODE_MIX      = 2'd0;
   localparam logic [1:0] MODE_THR_LOAD = 2'd1;
   localparam logic [1:0] MODE_PIT_LOAD = 2'd2;
   localparam logic [1:0] MODE_CO_LOAD  = 2'd3;

   // Servo coefficient selectors
   localparam logic [2:0] CO_PITCH_GAIN = 3'd0;
   localparam logic [2:0] CO_ROLL_GAIN  = 3'd1;
   localparam logic [2:0] CO_SCALE      = 3'd2;
   localparam logic [2:0] CO_OFFSET     = 3'd3;
   localparam logic [2:0] CO_MIN        = 3'd4;
   localparam logic [2:0] CO_MAX        = 3'd5;

   // Curve limits in Q2.14
   localparam logic signed [27:0] THR_LO  = 28'sd0;
   localparam logic signed [27:0] THR_HI  = 28'sd16384;
   localparam logic signed [27:0] COLL_LO = -28'sd8192;
   localparam logic signed [27:0] COLL_HI = 28'sd8192;

   typedef enum logic [3:0] {
      ST_IDLE, ST_THR, ST_PIT, ST_COLL, ST_GAIN, ST_ROLL, ST_SAT, ST_SCALE, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_THR_MUL, OP_PIT_MUL, OP_COLL, OP_GAIN_MUL, OP_ROLL_MUL, OP_SAT,
      OP_SCALE_MUL, OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [2:0] servo;
   } cmd_type;

   // Finish a curve segment: add base point, round half up to Q2.14
   function automatic logic signed [27:0] curve_fin(input logic signed [63:0] prod,
                                                    input logic signed [15:0] p0);
      logic signed [39:0] v;
      logic signed [39:0] r;
      v = 40'(prod) + (40'(p0) <<< 12);
      r = (v + 40'sd2048) >>> 12;
      return 28'(r);
   endfunction

   function automatic logic signed [27:0] clamp28(input logic signed [27:0] v,
                                                  input logic signed [27:0] lo,
                                                  input logic signed [27:0] hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

endpackage

/* rtl/swashplate_servo_mixer_core.sv */
// Mix transfer: the throttle result comes first, then one result per servo, n the servo count
// (capped at MAX_SERVOS); busy stays high until the last result. One multiplier is shared.
// Load transfers give no result; busy stays low.
// Synchronous active-high reset clears curves, coefficients and sets servo_count to 4.
// Results are strobed for one cycle; the receiver cannot stall.
module swashplate_servo_mixer_core import ssm_pkg::*; #(
   parameter int CURVE_POINTS = 5,
   parameter int MAX_SERVOS   = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [2:0]         req_slot,
   input  logic [2:0]         req_coef_select,
   input  logic signed [31:0] req_load_value,
   input  logic signed [15:0] req_thrust,
   input  logic signed [15:0] req_roll,
   input  logic signed [15:0] req_pitch,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_channel,
   output logic signed [31:0] rsp_value,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [2:0] servo_count_ff;
   logic       accept, mix_start, load_en;
   cmd_type    cmd;

   // Hold the servo count register
   always_ff @(posedge clock) begin
      if (reset) begin
         servo_count_ff <= 3'd4;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         servo_count_ff <= csr_pwdata[2:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(servo_count_ff);

   assign accept    = start && !busy;
   assign mix_start = accept && (req_mode == MODE_MIX);
   assign load_en   = accept && (req_mode != MODE_MIX);

   ssm_ctrl #(.MAX_SERVOS(MAX_SERVOS)) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .mix_start   (mix_start),
      .servo_count (servo_count_ff),
      .busy        (busy),
      .cmd         (cmd),
      .rsp_strobe  (rsp_strobe),
      .rsp_channel (rsp_channel),
      .rsp_last    (rsp_last)
   );

   ssm_datapath #(.CURVE_POINTS(CURVE_POINTS), .MAX_SERVOS(MAX_SERVOS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .load_en     (load_en),
      .mix_start   (mix_start),
      .mode        (req_mode),
      .slot        (req_slot),
      .coef_select (req_coef_select),
      .load_value  (req_load_value),
      .thrust_val  (req_thrust),
      .roll_val    (req_roll),
      .pitch_val   (req_pitch),
      .cmd         (cmd),
      .rsp_value   (rsp_value)
   );

endmodule

/* rtl/ssm_ctrl.sv */
module ssm_ctrl import ssm_pkg::*; #(
   parameter int MAX_SERVOS = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       mix_start,
   input  logic [2:0] servo_count,
   output logic       busy,
   output cmd_type    cmd,
   output logic       rsp_strobe,
   output logic [2:0] rsp_channel,
   output logic       rsp_last
);

   state_type  state_ff, state_in;
   logic [3:0] count_ff, count_in;
   logic [2:0] servo_ff, servo_in;
   logic [3:0] next_servo;

   // Hold state, servo count and current servo
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         servo_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         servo_ff <= servo_in;
      end
   end

   assign next_servo = 4'(servo_ff) + 4'd1;

   // Sequence one mix through the shared multiplier
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      servo_in    = servo_ff;
      cmd.op      = OP_NONE;
      cmd.servo   = servo_ff;
      rsp_strobe  = 1'b0;
      rsp_channel = '0;
      rsp_last    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (mix_start) begin
               count_in = (4'(servo_count) > 4'(MAX_SERVOS)) ? 4'(MAX_SERVOS)
                                                            : 4'(servo_count);
               servo_in = '0;
               state_in = ST_THR;
            end
         end
         ST_THR: begin
            cmd.op   = OP_THR_MUL;
            state_in = ST_PIT;
         end
         ST_PIT: begin
            cmd.op     = OP_PIT_MUL;
            rsp_strobe = 1'b1;
            rsp_last   = (count_ff == 4'd0);
            state_in   = ST_COLL;
         end
         ST_COLL: begin
            cmd.op   = OP_COLL;
            state_in = (count_ff == 4'd0) ? ST_IDLE : ST_GAIN;
         end
         ST_GAIN: begin
            cmd.op   = OP_GAIN_MUL;
            state_in = ST_ROLL;
         end
         ST_ROLL: begin
            cmd.op   = OP_ROLL_MUL;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.op   = OP_SAT;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.op   = OP_SCALE_MUL;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.op      = OP_OUT;
            rsp_strobe  = 1'b1;
            rsp_channel = 3'(next_servo);
            rsp_last    = (next_servo == count_ff);
            if (next_servo == count_ff) begin
               state_in = ST_IDLE;
            end else begin
               servo_in = 3'(next_servo);
               state_in = ST_GAIN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/ssm_datapath.sv */
module ssm_datapath import ssm_pkg::*; #(
   parameter int CURVE_POINTS = 5,
   parameter int MAX_SERVOS   = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               load_en,
   input  logic               mix_start,
   input  logic [1:0]         mode,
   input  logic [2:0]         slot,
   input  logic [2:0]         coef_select,
   input  logic signed [31:0] load_value,
   input  logic signed [15:0] thrust_val,
   input  logic signed [15:0] roll_val,
   input  logic signed [15:0] pitch_val,
   input  cmd_type            cmd,
   output logic signed [31:0] rsp_value
);

   localparam int PT_W = $clog2(CURVE_POINTS);
   localparam int SV_W = (MAX_SERVOS > 1) ? $clog2(MAX_SERVOS) : 1;

   logic signed [15:0] thr_pts_ff [CURVE_POINTS];
   logic signed [15:0] pit_pts_ff [CURVE_POINTS];
   logic signed [31:0] gain_ff [MAX_SERVOS];
   logic signed [31:0] rgain_ff [MAX_SERVOS];
   logic signed [31:0] scale_ff [MAX_SERVOS];
   logic signed [31:0] offs_ff [MAX_SERVOS];
   logic signed [31:0] min_ff [MAX_SERVOS];
   logic signed [31:0] max_ff [MAX_SERVOS];

   logic [PT_W-1:0]    idx_ff, idx_in, idx1;
   logic signed [17:0] dt_ff, dt_in;
   logic signed [15:0] roll_ff, pitch_ff;
   logic signed [63:0] prod_ff;
   logic signed [51:0] acc_ff;
   logic signed [27:0] coll_ff;
   logic signed [31:0] m_ff;

   logic [PT_W-1:0]    pt_waddr;
   logic [SV_W-1:0]    sv_waddr, sv;
   logic [2:0]         raw_idx;
   logic signed [32:0] mul_a, mul_b;
   logic signed [27:0] thr_c, coll_c;
   logic signed [51:0] sum;
   logic signed [37:0] sum_r;
   logic signed [64:0] scaled;
   logic signed [49:0] outv;

   assign pt_waddr = PT_W'(slot);
   assign sv_waddr = SV_W'(slot);
   assign sv       = SV_W'(cmd.servo);
   assign idx1     = PT_W'(idx_ff + 1'b1);

   // Write curve points and coefficients on load transfers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CURVE_POINTS; i++) begin
            thr_pts_ff[i] <= '0;
            pit_pts_ff[i] <= '0;
         end
         for (int i = 0; i < MAX_SERVOS; i++) begin
            gain_ff[i]  <= '0;
            rgain_ff[i] <= '0;
            scale_ff[i] <= '0;
            offs_ff[i]  <= '0;
            min_ff[i]   <= '0;
            max_ff[i]   <= '0;
         end
      end else if (load_en) begin
         if (mode == MODE_CO_LOAD) begin
            if (5'(slot) < 5'(MAX_SERVOS)) begin
               unique case (coef_select)
                  CO_PITCH_GAIN: gain_ff[sv_waddr]  <= load_value;
                  CO_ROLL_GAIN:  rgain_ff[sv_waddr] <= load_value;
                  CO_SCALE:      scale_ff[sv_waddr] <= load_value;
                  CO_OFFSET:     offs_ff[sv_waddr]  <= load_value;
                  CO_MIN:        min_ff[sv_waddr]   <= load_value;
                  CO_MAX:        max_ff[sv_waddr]   <= load_value;
                  default: ;
               endcase
            end
         end else if (6'(slot) < 6'(CURVE_POINTS)) begin
            if (mode == MODE_THR_LOAD) begin
               thr_pts_ff[pt_waddr] <= load_value[15:0];
            end else if (mode == MODE_PIT_LOAD) begin
               pit_pts_ff[pt_waddr] <= load_value[15:0];
            end
         end
      end
   end

   // Pick the segment and offset into it
   always_comb begin
      raw_idx = thrust_val[15] ? 3'd0 : thrust_val[14:12];
      if (6'(raw_idx) > 6'(CURVE_POINTS - 2)) begin
         idx_in = PT_W'(CURVE_POINTS - 2);
      end else begin
         idx_in = PT_W'(raw_idx);
      end
      dt_in = 18'(thrust_val) - signed'({2'b00, 4'(idx_in), 12'd0});
   end

   // Latch the segment, offset and roll/pitch inputs at the mix transfer
   always_ff @(posedge clock) begin
      if (mix_start) begin
         idx_ff   <= idx_in;
         dt_ff    <= dt_in;
         roll_ff  <= roll_val;
         pitch_ff <= pitch_val;
      end
   end

   // Select operands of the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_THR_MUL: begin
            mul_a = 33'(17'(thr_pts_ff[idx1]) - 17'(thr_pts_ff[idx_ff]));
            mul_b = 33'(dt_ff);
         end
         OP_PIT_MUL: begin
            mul_a = 33'(17'(pit_pts_ff[idx1]) - 17'(pit_pts_ff[idx_ff]));
            mul_b = 33'(dt_ff);
         end
         OP_GAIN_MUL: begin
            mul_a = 33'(gain_ff[sv]);
            mul_b = 33'(pitch_ff);
         end
         OP_ROLL_MUL: begin
            mul_a = 33'(rgain_ff[sv]);
            mul_b = 33'(roll_ff);
         end
         OP_SCALE_MUL: begin
            mul_a = 33'(m_ff);
            mul_b = 33'(scale_ff[sv]);
         end
         default: ;
      endcase
   end

   // Finish curves, servo sum and output stage
   always_comb begin
      thr_c  = clamp28(curve_fin(prod_ff, thr_pts_ff[idx_ff]), THR_LO, THR_HI);
      coll_c = clamp28(curve_fin(prod_ff, pit_pts_ff[idx_ff]), COLL_LO, COLL_HI);
      sum    = acc_ff - 52'(prod_ff);
      sum_r  = 38'((sum + 52'sd8192) >>> 14);
      scaled = (65'(prod_ff) + 65'sd32768) >>> 16;
      outv   = 50'(scaled) + 50'(offs_ff[sv]);
   end

   // Advance the datapath registers
   always_ff @(posedge clock) begin
      if (cmd.op != OP_NONE) begin
         prod_ff <= 64'(mul_a * mul_b);
      end
      if (cmd.op == OP_COLL) begin
         coll_ff <= coll_c;
      end
      if (cmd.op == OP_ROLL_MUL) begin
         acc_ff <= (52'(coll_ff) <<< 16) + 52'(prod_ff);
      end
      if (cmd.op == OP_SAT) begin
         if (sum_r > 38'sd2147483647) begin
            m_ff <= 32'sh7FFFFFFF;
         end else if (sum_r < -38'sd2147483648) begin
            m_ff <= 32'sh80000000;
         end else begin
            m_ff <= 32'(sum_r);
         end
      end
   end

   // Drive the result value
   always_comb begin
      if (cmd.op == OP_OUT) begin
         if (outv < 50'(min_ff[sv])) begin
            rsp_value = min_ff[sv];
         end else if (outv > 50'(max_ff[sv])) begin
            rsp_value = max_ff[sv];
         end else begin
            rsp_value = 32'(outv);
         end
      end else begin
         rsp_value = 32'(thr_c) <<< 2;
      end
   end

endmodule
